FILE: hw/rtl/pxu_pkg.sv
// pxu_pkg: shared types and constants for the pixel unpack block
// no dependencies; used by pxu_unpack and pixel_unpack_to_argb32
package pxu_pkg;

  localparam int PixelBytesW = 64;
  localparam int SubIndexW   = 3;
  localparam int ArgbW       = 32;
  localparam int FormatW     = 4;

  // stored pixel format codes; any code not listed is unknown
  typedef enum logic [FormatW-1:0] {
    FMT_GREY1        = 4'd0,
    FMT_GREY2        = 4'd1,
    FMT_GREY4        = 4'd2,
    FMT_GREY8        = 4'd3,
    FMT_GREY16       = 4'd4,
    FMT_GREYALPHA16  = 4'd5,
    FMT_GREYALPHA32  = 4'd6,
    FMT_RGB24        = 4'd7,
    FMT_RGB48        = 4'd8,
    FMT_ARGB32       = 4'd9,
    FMT_ARGB64       = 4'd10,
    FMT_RGBA32       = 4'd11,
    FMT_RGBA64       = 4'd12
  } fmt_t;

  localparam fmt_t FmtReset = FMT_GREY8;

  localparam logic [ArgbW-1:0] OpaqueAlpha = 32'hFF00_0000;
  localparam logic [ArgbW-1:0] White       = 32'hFFFF_FFFF;
  localparam logic [ArgbW-1:0] Unknown     = 32'h0000_0000;
  localparam logic [7:0]       AlphaFull   = 8'hFF;

endpackage

FILE: hw/rtl/pxu_unpack.sv
// pxu_unpack: combinational decode of one stored pixel into argb8888
// depends on pxu_pkg (format codes, widths, constants)
module pxu_unpack (
  input  pxu_pkg::fmt_t                       fmt,
  input  logic [pxu_pkg::PixelBytesW-1:0]     pixel_bytes,
  input  logic [pxu_pkg::SubIndexW-1:0]       sub_index,
  output logic [pxu_pkg::ArgbW-1:0]           argb
);

  logic [7:0] b [8];
  logic [1:0] g2;
  logic [3:0] g4;
  logic       g1;
  logic [7:0] g2_wide;
  logic [7:0] g4_wide;

  // b[0] is the first byte in memory
  for (genvar k = 0; k < 8; k++) begin : g_bytes
    assign b[k] = pixel_bytes[63-8*k -: 8];
  end

  // samples are taken from the top of the byte first
  assign g1 = b[0][~sub_index];

  always_comb begin
    case (sub_index[1:0])
      2'd0:    g2 = b[0][7:6];
      2'd1:    g2 = b[0][5:4];
      2'd2:    g2 = b[0][3:2];
      default: g2 = b[0][1:0];
    endcase
  end

  assign g4      = sub_index[0] ? b[0][3:0] : b[0][7:4];
  assign g2_wide = {4{g2}};
  assign g4_wide = {2{g4}};

  always_comb begin
    unique case (fmt)
      pxu_pkg::FMT_GREY1:
        argb = g1 ? pxu_pkg::White : pxu_pkg::OpaqueAlpha;
      pxu_pkg::FMT_GREY2:
        argb = {pxu_pkg::AlphaFull, g2_wide, g2_wide, g2_wide};
      pxu_pkg::FMT_GREY4:
        argb = {pxu_pkg::AlphaFull, g4_wide, g4_wide, g4_wide};
      pxu_pkg::FMT_GREY8, pxu_pkg::FMT_GREY16:
        argb = {pxu_pkg::AlphaFull, b[0], b[0], b[0]};
      pxu_pkg::FMT_GREYALPHA16:
        argb = {b[1], b[0], b[0], b[0]};
      pxu_pkg::FMT_GREYALPHA32:
        argb = {b[2], b[0], b[0], b[0]};
      pxu_pkg::FMT_RGB24:
        argb = {pxu_pkg::AlphaFull, b[0], b[1], b[2]};
      pxu_pkg::FMT_RGB48:
        argb = {pxu_pkg::AlphaFull, b[0], b[2], b[4]};
      pxu_pkg::FMT_ARGB32:
        argb = {b[0], b[1], b[2], b[3]};
      pxu_pkg::FMT_ARGB64:
        argb = {b[0], b[2], b[4], b[6]};
      pxu_pkg::FMT_RGBA32:
        argb = {b[3], b[0], b[1], b[2]};
      pxu_pkg::FMT_RGBA64:
        argb = {b[6], b[0], b[2], b[4]};
      default:
        argb = pxu_pkg::Unknown;
    endcase
  end

endmodule

FILE: hw/rtl/pixel_unpack_to_argb32.sv
// throughput: one beat per cycle while out_stall is low; an accepted beat goes
// through the input register, then the result register; these two registers form a
// two-deep pipeline, so a new beat is taken while a result waits
// reset (rst, synchronous): both pipeline stages empty, format set to grey8
// pixel_unpack_to_argb32: top level; depends on pxu_pkg and pxu_unpack
module pixel_unpack_to_argb32 (
  input  logic                                clk,
  input  logic                                rst,
  // format register write
  input  logic                                cfg_wr_en,
  input  logic [pxu_pkg::FormatW-1:0]         cfg_wr_data,
  // pixel input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pxu_pkg::PixelBytesW-1:0]     pixel_bytes,
  input  logic [pxu_pkg::SubIndexW-1:0]       sub_index,
  // argb result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pxu_pkg::ArgbW-1:0]           argb
);

  // configured format; user changes it only while pipeline is empty; not enforced
  pxu_pkg::fmt_t                       pixel_format;

  // input register stage
  logic                                s1_valid;
  logic [pxu_pkg::PixelBytesW-1:0]     s1_bytes;
  logic [pxu_pkg::SubIndexW-1:0]       s1_sub;

  // result register stage
  logic [pxu_pkg::ArgbW-1:0]           argb_next;

  logic                                out_free;
  logic                                s1_advance;
  logic                                in_take;

  // the result register can take a new beat when empty or being drained
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  // input register frees up when empty or moving on this cycle
  assign in_stall   = s1_valid && !out_free;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= pxu_pkg::FmtReset;
    end else if (cfg_wr_en) begin
      pixel_format <= pxu_pkg::fmt_t'(cfg_wr_data);
    end
  end

  // input register: valid bit cleared by reset, payload not
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_bytes <= pixel_bytes;
      s1_sub   <= sub_index;
    end
  end

  // byte selection and grey widening between the two registers
  pxu_unpack u_unpack (
    .fmt         (pixel_format),
    .pixel_bytes (s1_bytes),
    .sub_index   (s1_sub),
    .argb        (argb_next)
  );

  // result register: loads when a beat moves on, empties when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      argb <= argb_next;
    end
  end

endmodule

FILE: hw/rtl/pxu_checker.sv
// pxu_checker: port-level assertions for pixel_unpack_to_argb32
// bound to the top level below; needs no package
module pxu_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [3:0]  cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [63:0] pixel_bytes,
  input logic [2:0]  sub_index,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] argb
);

  // a stalled result beat stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(argb))
    else $error("stalled result beat changed");

  // reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // input can only back up when a result is waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // an accepted beat reaches the output through both registers if the output does not stall it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind pixel_unpack_to_argb32 pxu_checker u_pxu_checker (.*);
